@@ sv/colon_command_line_parser_defines.svh @@
// ============================================================================
// Colon command line parser: assertion macros
// Shared concurrent assertion forms used by the parser's checks.
// ============================================================================
`ifndef COLON_COMMAND_LINE_PARSER_DEFINES_SVH
`define COLON_COMMAND_LINE_PARSER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define CCL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge.
`define CCL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/ccl_pkg.sv @@
// ============================================================================
// Colon command line parser package
// Types, codes and keyword tables used by the front and back parts.
// ============================================================================
package ccl_pkg;

    // Width of the internal argument accumulator and of the result ports.
    localparam int ARG_WIDTH  = 32;
    localparam int ARG_PORT_W = 32;

    localparam int CHAR_W  = 8;
    localparam int CMD_W   = 3;
    localparam int COUNT_W = 8;
    localparam int POS_W   = 4;
    localparam int DIGIT_W = 4;

    localparam logic [COUNT_W-1:0] TOKEN_MAX = '1;
    localparam logic [POS_W-1:0]   POS_MAX   = '1;

    // Depth of the queue between the front and back parts.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // Character classes produced by the front part.
    typedef logic [2:0] ccl_kind_t;
    localparam ccl_kind_t KIND_OTHER = 3'd0;
    localparam ccl_kind_t KIND_SPACE = 3'd1;
    localparam ccl_kind_t KIND_SIGN  = 3'd2;
    localparam ccl_kind_t KIND_DIGIT = 3'd3;
    localparam ccl_kind_t KIND_COLON = 3'd4;
    localparam ccl_kind_t KIND_EOL   = 3'd5;

    typedef struct packed {
        ccl_kind_t           kind;
        logic                negative;
        logic [DIGIT_W-1:0]  digit;
        logic [CHAR_W-1:0]   ch;
    } ccl_item_t;

    // Command codes.
    localparam logic [CMD_W-1:0] CMD_UNKNOWN      = 3'd0;
    localparam logic [CMD_W-1:0] CMD_TOGGLE_ALL   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TOGGLE_ONE   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PWM          = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PAUSE_ALL    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_PAUSE_ONE    = 3'd5;

    // Keyword table, first character first, padded with zeros.
    localparam int KW_COUNT  = 5;
    localparam int KW_MAXLEN = 13;

    localparam logic [CHAR_W-1:0] KW_CHARS [KW_COUNT][KW_MAXLEN] = '{
        '{"t", "o", "g", "g", "l", "e", "E", "x", "e", "c", "A", "l", "l"},
        '{"t", "o", "g", "g", "l", "e", "E", "x", "e", "c", 8'h00, 8'h00, 8'h00},
        '{"p", "w", "m", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00, 8'h00},
        '{"d", "e", "l", "a", "y", "A", "l", "l", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"d", "e", "l", "a", "y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
          8'h00, 8'h00}
    };

    localparam logic [POS_W-1:0] KW_LEN [KW_COUNT] = '{
        4'd13, 4'd10, 4'd3, 4'd8, 4'd5
    };

    localparam logic [CMD_W-1:0] KW_CODE [KW_COUNT] = '{
        CMD_TOGGLE_ALL, CMD_TOGGLE_ONE, CMD_PWM, CMD_PAUSE_ALL, CMD_PAUSE_ONE
    };

endpackage

@@ sv/colon_command_line_parser.sv @@
// ============================================================================
// Colon command line parser
// Parses a colon-separated command line into a command code, two decimal
// arguments and an argument count.
// ============================================================================
//  Channel   Direction   Handshake         Payload
//  line      in          push / full       ch, end_of_line
//  result    out         empty / pop       command, first_arg, second_arg, arg_count
//
// One character or terminator is taken per cycle while full is low; the back
// part retires one queued transaction per cycle unless a terminator waits for
// an unread result, so the sustained rate is one per clock while results are
// popped. A terminator goes into a queue entry, then into the result register.
// Reset clears all control state at once; no clearing pass is needed.
// A terminator waits in the four-entry queue while the previous result is
// unread; full rises once four transactions are waiting.
module colon_command_line_parser
    import ccl_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [CHAR_W-1:0]           ch,
    input  logic                        end_of_line,
    input  logic                        push,
    output logic                        full,
    output logic [CMD_W-1:0]            command,
    output logic signed [ARG_PORT_W-1:0] first_arg,
    output logic signed [ARG_PORT_W-1:0] second_arg,
    output logic [COUNT_W-1:0]          arg_count,
    output logic                        empty,
    input  logic                        pop
);

`include "colon_command_line_parser_defines.svh"

    logic       q_valid;
    ccl_item_t  q_item;
    logic       q_take;

    ccl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .ch          (ch),
        .end_of_line (end_of_line),
        .push        (push),
        .full        (full),
        .q_valid     (q_valid),
        .q_item      (q_item),
        .q_take      (q_take)
    );

    ccl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_valid),
        .q_item     (q_item),
        .q_take     (q_take),
        .command    (command),
        .first_arg  (first_arg),
        .second_arg (second_arg),
        .arg_count  (arg_count),
        .empty      (empty),
        .pop        (pop)
    );

    // A full queue always presents a transaction to the back part.
    `CCL_ASSERT_NOW(a_full_has_item, full, q_valid, "queue full but no item presented")

    // A terminator meeting a free result register is retired at once.
    `CCL_ASSERT_NEXT(a_eol_makes_result, q_valid && q_item.kind == KIND_EOL && empty, !empty, "terminator did not produce a result")

    // A popped result is gone unless a new terminator replaced it.
    `CCL_ASSERT_NEXT(a_pop_clears, pop && !empty && !(q_valid && q_item.kind == KIND_EOL), empty, "result still shown after pop")

    // A terminator is retired over an unread result only when that result is popped.
    `CCL_ASSERT_NOW(a_no_overwrite, q_take && q_item.kind == KIND_EOL && !empty, pop, "unread result overwritten")

endmodule

@@ sv/ccl_front.sv @@
// ============================================================================
// Colon command line parser: front part
// Accepts characters and terminators, classifies them and queues them.
// ============================================================================
module ccl_front
    import ccl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [CHAR_W-1:0]   ch,
    input  logic                end_of_line,
    input  logic                push,
    output logic                full,
    output logic                q_valid,
    output ccl_item_t           q_item,
    input  logic                q_take
);

    ccl_item_t                  entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0]     wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0]     wr_ptr_next;
    logic [QUEUE_PTR_W-1:0]     rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0]     rd_ptr_next;
    logic [QUEUE_CNT_W-1:0]     count_reg;
    logic [QUEUE_CNT_W-1:0]     count_next;
    ccl_item_t                  item_in;
    logic                       wr_en;
    logic                       rd_en;

    // Classify the incoming transaction.
    always_comb
    begin
        item_in.ch       = ch;
        item_in.negative = (ch == "-");
        item_in.digit    = DIGIT_W'(ch - "0");
        if (end_of_line)
        begin
            item_in.kind = KIND_EOL;
        end
        else if (ch == ":")
        begin
            item_in.kind = KIND_COLON;
        end
        else if (ch == " " || (ch >= 8'd9 && ch <= 8'd13))
        begin
            item_in.kind = KIND_SPACE;
        end
        else if (ch == "+" || ch == "-")
        begin
            item_in.kind = KIND_SIGN;
        end
        else if (ch >= "0" && ch <= "9")
        begin
            item_in.kind = KIND_DIGIT;
        end
        else
        begin
            item_in.kind = KIND_OTHER;
        end
    end

    assign full    = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_item  = entry_reg[rd_ptr_reg];
    assign wr_en   = push && !full;
    assign rd_en   = q_take && q_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entry_reg[wr_ptr_reg] <= item_in;
        end
    end

endmodule

@@ sv/ccl_back.sv @@
// ============================================================================
// Colon command line parser: back part
// Tokenizes classified items, matches the keyword, converts the arguments
// and holds the finished result until it is popped.
// ============================================================================
module ccl_back
    import ccl_pkg::*;
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        q_valid,
    input  ccl_item_t                   q_item,
    output logic                        q_take,
    output logic [CMD_W-1:0]            command,
    output logic signed [ARG_PORT_W-1:0] first_arg,
    output logic signed [ARG_PORT_W-1:0] second_arg,
    output logic [COUNT_W-1:0]          arg_count,
    output logic                        empty,
    input  logic                        pop
);

    localparam logic [1:0] PHASE_SKIP   = 2'd0;
    localparam logic [1:0] PHASE_SIGN   = 2'd1;
    localparam logic [1:0] PHASE_DIGITS = 2'd2;
    localparam logic [1:0] PHASE_DONE   = 2'd3;

    function automatic logic [ARG_PORT_W-1:0] arg_to_port(input logic [ARG_WIDTH-1:0] v);
        logic [63:0] wide;
        wide = 64'(v);
        return wide[ARG_PORT_W-1:0];
    endfunction

    logic [COUNT_W-1:0]     token_number_reg, token_number_next;
    logic                   token_seen_reg, token_seen_next;
    logic                   in_token_reg, in_token_next;
    logic [POS_W-1:0]       char_pos_reg, char_pos_next;
    logic [KW_COUNT-1:0]    kw_flags_reg, kw_flags_next;
    logic [1:0]             phase_reg, phase_next;
    logic                   negative_reg, negative_next;
    logic [ARG_WIDTH-1:0]   acc_reg, acc_next;
    logic [CMD_W-1:0]       held_cmd_reg, held_cmd_next;
    logic [ARG_WIDTH-1:0]   held_a1_reg, held_a1_next;
    logic [ARG_WIDTH-1:0]   held_a2_reg, held_a2_next;

    logic                   out_valid_reg, out_valid_next;
    logic [CMD_W-1:0]       command_reg;
    logic [ARG_PORT_W-1:0]  first_arg_reg;
    logic [ARG_PORT_W-1:0]  second_arg_reg;
    logic [COUNT_W-1:0]     arg_count_reg;

    logic                   pop_ok;
    logic                   is_eol;
    logic                   load_out;
    logic [CMD_W-1:0]       fin_code;
    logic [ARG_WIDTH-1:0]   fin_val;
    logic [CMD_W-1:0]       h_cmd;
    logic [ARG_WIDTH-1:0]   h_a1;
    logic [ARG_WIDTH-1:0]   h_a2;

    assign pop_ok   = pop && out_valid_reg;
    assign is_eol   = (q_item.kind == KIND_EOL);
    // A terminator needs the result register free, or freed in this cycle.
    assign q_take   = q_valid && (!is_eol || !out_valid_reg || pop);
    assign load_out = q_take && is_eol;

    // Value of the token that is open, should it end now.
    always_comb
    begin
        fin_code = CMD_UNKNOWN;
        for (int k = 0; k < KW_COUNT; k++)
        begin
            if (kw_flags_reg[k] && char_pos_reg == KW_LEN[k])
            begin
                fin_code = KW_CODE[k];
            end
        end
        fin_val = negative_reg ? (~acc_reg) + ARG_WIDTH'(1) : acc_reg;

        h_cmd = held_cmd_reg;
        h_a1  = held_a1_reg;
        h_a2  = held_a2_reg;
        if (in_token_reg)
        begin
            if (token_number_reg == COUNT_W'(0))
            begin
                h_cmd = fin_code;
            end
            else if (token_number_reg == COUNT_W'(1))
            begin
                h_a1 = fin_val;
            end
            else if (token_number_reg == COUNT_W'(2))
            begin
                h_a2 = fin_val;
            end
        end
    end

    always_comb
    begin
        token_number_next = token_number_reg;
        token_seen_next   = token_seen_reg;
        in_token_next     = in_token_reg;
        char_pos_next     = char_pos_reg;
        kw_flags_next     = kw_flags_reg;
        phase_next        = phase_reg;
        negative_next     = negative_reg;
        acc_next          = acc_reg;
        held_cmd_next     = held_cmd_reg;
        held_a1_next      = held_a1_reg;
        held_a2_next      = held_a2_reg;

        if (q_take)
        begin
            case (q_item.kind)
                KIND_EOL:
                begin
                    token_number_next = '0;
                    token_seen_next   = 1'b0;
                    in_token_next     = 1'b0;
                    char_pos_next     = '0;
                    kw_flags_next     = '1;
                    phase_next        = PHASE_SKIP;
                    negative_next     = 1'b0;
                    acc_next          = '0;
                    held_cmd_next     = CMD_UNKNOWN;
                    held_a1_next      = '0;
                    held_a2_next      = '0;
                end
                KIND_COLON:
                begin
                    if (in_token_reg)
                    begin
                        held_cmd_next = h_cmd;
                        held_a1_next  = h_a1;
                        held_a2_next  = h_a2;
                        in_token_next = 1'b0;
                        char_pos_next = '0;
                        kw_flags_next = '1;
                        phase_next    = PHASE_SKIP;
                        negative_next = 1'b0;
                        acc_next      = '0;
                    end
                end
                default:
                begin
                    if (!in_token_reg)
                    begin
                        in_token_next = 1'b1;
                        if (!token_seen_reg)
                        begin
                            token_seen_next = 1'b1;
                        end
                        else if (token_number_reg != TOKEN_MAX)
                        begin
                            token_number_next = token_number_reg + 1'b1;
                        end
                    end
                    // Outside a token the position is zero and all flags are set.
                    for (int k = 0; k < KW_COUNT; k++)
                    begin
                        if (!(char_pos_reg < KW_LEN[k] &&
                              KW_CHARS[k][char_pos_reg] == q_item.ch))
                        begin
                            kw_flags_next[k] = 1'b0;
                        end
                    end
                    if (char_pos_reg != POS_MAX)
                    begin
                        char_pos_next = char_pos_reg + 1'b1;
                    end

                    if (phase_reg == PHASE_SKIP && q_item.kind == KIND_SPACE)
                    begin
                        phase_next = PHASE_SKIP;
                    end
                    else if (phase_reg == PHASE_SKIP && q_item.kind == KIND_SIGN)
                    begin
                        negative_next = q_item.negative;
                        phase_next    = PHASE_SIGN;
                    end
                    else if (phase_reg != PHASE_DONE && q_item.kind == KIND_DIGIT)
                    begin
                        acc_next   = (acc_reg << 3) + (acc_reg << 1) +
                                     ARG_WIDTH'(q_item.digit);
                        phase_next = PHASE_DIGITS;
                    end
                    else
                    begin
                        phase_next = PHASE_DONE;
                    end
                end
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (pop_ok)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            token_number_reg <= '0;
            token_seen_reg   <= 1'b0;
            in_token_reg     <= 1'b0;
            char_pos_reg     <= '0;
            kw_flags_reg     <= '1;
            phase_reg        <= PHASE_SKIP;
            negative_reg     <= 1'b0;
            acc_reg          <= '0;
            held_cmd_reg     <= CMD_UNKNOWN;
            held_a1_reg      <= '0;
            held_a2_reg      <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            token_number_reg <= token_number_next;
            token_seen_reg   <= token_seen_next;
            in_token_reg     <= in_token_next;
            char_pos_reg     <= char_pos_next;
            kw_flags_reg     <= kw_flags_next;
            phase_reg        <= phase_next;
            negative_reg     <= negative_next;
            acc_reg          <= acc_next;
            held_cmd_reg     <= held_cmd_next;
            held_a1_reg      <= held_a1_next;
            held_a2_reg      <= held_a2_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            command_reg    <= h_cmd;
            first_arg_reg  <= arg_to_port(h_a1);
            second_arg_reg <= arg_to_port(h_a2);
            arg_count_reg  <= token_seen_reg ? token_number_reg : '0;
        end
    end

    assign empty      = !out_valid_reg;
    assign command    = command_reg;
    assign first_arg  = first_arg_reg;
    assign second_arg = second_arg_reg;
    assign arg_count  = arg_count_reg;

endmodule
